// ===== rtl/core/qes_pkg.sv =====
// shared types and constants for the quadrature encoder speed block
// used by qes_ctrl, qes_datapath and quadrature_encoder_speed; no dependencies
package qes_pkg;

    // internal widths of the position counter and of the time base
    localparam int COUNT_WIDTH = 32;
    localparam int TIME_WIDTH  = 32;

    // fixed field widths
    localparam int POS_W    = 32;
    localparam int DIR_W    = 2;
    localparam int PERIOD_W = 32;
    localparam int TS_W     = 32;
    localparam int WIN_W    = 16;
    localparam int SCALE_W  = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(SCALE_W);

    // configuration reset values
    localparam logic [WIN_W-1:0]   STALL_WINDOW_RST = WIN_W'(5000);
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST  = SCALE_W'(600000);
    localparam logic [WIN_W-1:0]   WIN_MAX          = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STALL_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 1'b1;

    // request codes
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_CW      = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CCW     = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // take the input beat, update state, start divide
        logic div_step;  // one restoring division step
        logic out_load;  // copy results into the output register
    } qes_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;  // current division step is the final one
    } qes_status_t;

endpackage

// ===== rtl/core/qes_ctrl.sv =====
// sequencing state machine: accept, divide, hand result to output register
// depends on qes_pkg
module qes_ctrl
    import qes_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  qes_status_t status,
    output qes_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/core/qes_datapath.sv =====
// encoder state, stall window, serial rpm divider and output register
// depends on qes_pkg
module qes_datapath
    import qes_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_req_type,
    input  logic                 s_phase_b_level,
    input  logic [TS_W-1:0]      s_timestamp_us,
    input  qes_cmd_t             cmd,
    output qes_status_t          status,
    output logic signed [POS_W-1:0] m_position,
    output logic [DIR_W-1:0]     m_direction,
    output logic [PERIOD_W-1:0]  m_period_us,
    output logic [SCALE_W-1:0]   m_speed_rpm,
    output logic                 m_ready_res
);

    logic [WIN_W-1:0]       stall_window_reg;
    logic [SCALE_W-1:0]     speed_scale_reg;

    logic [COUNT_WIDTH-1:0] edge_count_reg, edge_count_next;
    logic [TIME_WIDTH-1:0]  last_time_reg, last_time_next;
    logic [TIME_WIDTH-1:0]  period_reg, period_next;
    logic [DIR_W-1:0]       dir_reg, dir_next;
    logic [COUNT_WIDTH-1:0] snapshot_reg, snapshot_next;
    logic [WIN_W-1:0]       timer_reg, timer_next;
    logic                   started_reg, started_next;

    logic [TIME_WIDTH-1:0]  ts;
    logic [WIN_W-1:0]       timer_inc;

    // divider: dividend bits shift out the top, quotient bits shift in
    logic [SCALE_W-1:0]     quo_reg, quo_next;
    logic [TIME_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_WIDTH:0]    rem_shift;
    logic                   fits;

    logic signed [POS_W-1:0] pos_val;
    logic [PERIOD_W-1:0]     period_val;

    generate
        if (TIME_WIDTH >= TS_W) begin : g_ts_wide
            assign ts = TIME_WIDTH'(s_timestamp_us);
        end else begin : g_ts_narrow
            assign ts = s_timestamp_us[TIME_WIDTH-1:0];
        end
        if (COUNT_WIDTH >= POS_W) begin : g_pos_wide
            assign pos_val = edge_count_reg[POS_W-1:0];
        end else begin : g_pos_narrow
            assign pos_val = {{(POS_W-COUNT_WIDTH){edge_count_reg[COUNT_WIDTH-1]}},
                              edge_count_reg};
        end
        if (TIME_WIDTH >= PERIOD_W) begin : g_per_wide
            assign period_val = period_reg[PERIOD_W-1:0];
        end else begin : g_per_narrow
            assign period_val = PERIOD_W'(period_reg);
        end
    endgenerate

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_window_reg <= STALL_WINDOW_RST;
            speed_scale_reg  <= SPEED_SCALE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_STALL_WINDOW: stall_window_reg <= cfg_wr_data[WIN_W-1:0];
                REG_SPEED_SCALE:  speed_scale_reg  <= cfg_wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign timer_inc = (timer_reg == WIN_MAX) ? timer_reg : timer_reg + 1'b1;

    // state update for one accepted beat
    always_comb begin
        edge_count_next = edge_count_reg;
        last_time_next  = last_time_reg;
        period_next     = period_reg;
        dir_next        = dir_reg;
        snapshot_next   = snapshot_reg;
        timer_next      = timer_reg;
        started_next    = started_reg;
        if (cmd.load) begin
            if (s_req_type == REQ_EDGE) begin
                period_next    = ts - last_time_reg;
                last_time_next = ts;
                if (s_phase_b_level) begin
                    dir_next        = DIR_CCW;
                    edge_count_next = edge_count_reg - 1'b1;
                end else begin
                    dir_next        = DIR_CW;
                    edge_count_next = edge_count_reg + 1'b1;
                end
            end else if (!started_reg) begin
                snapshot_next = edge_count_reg;
                started_next  = 1'b1;
                timer_next    = '0;
            end else begin
                timer_next = timer_inc;
                if (timer_inc >= stall_window_reg) begin
                    if (edge_count_reg == snapshot_reg) begin
                        period_next = '0;
                        dir_next    = DIR_UNKNOWN;
                    end
                    snapshot_next = edge_count_reg;
                    timer_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_count_reg <= '0;
            last_time_reg  <= '0;
            period_reg     <= '0;
            dir_reg        <= DIR_UNKNOWN;
            snapshot_reg   <= '0;
            timer_reg      <= '0;
            started_reg    <= 1'b0;
        end else begin
            edge_count_reg <= edge_count_next;
            last_time_reg  <= last_time_next;
            period_reg     <= period_next;
            dir_reg        <= dir_next;
            snapshot_reg   <= snapshot_next;
            timer_reg      <= timer_next;
            started_reg    <= started_next;
        end
    end

    // restoring division of speed_scale by the period, one bit per step
    assign rem_shift = {rem_reg, quo_reg[SCALE_W-1]};
    assign fits      = (rem_shift >= {1'b0, period_reg});
    assign status.div_last = (cnt_reg == DIV_CNT_W'(SCALE_W - 1));

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            quo_next = speed_scale_reg;
            rem_next = '0;
            cnt_next = '0;
        end else if (cmd.div_step) begin
            quo_next = {quo_reg[SCALE_W-2:0], fits};
            rem_next = fits ? TIME_WIDTH'(rem_shift - {1'b0, period_reg})
                            : rem_shift[TIME_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_position  <= pos_val;
            m_direction <= dir_reg;
            m_period_us <= period_val;
            m_speed_rpm <= (period_reg == '0) ? '0 : quo_reg;
            m_ready_res <= started_reg;
        end
    end

endmodule

// ===== rtl/core/quadrature_encoder_speed.sv =====
// top level of the x1 quadrature decoder with period-based rpm
// depends on qes_pkg, qes_ctrl and qes_datapath
//
// each input beat is either a phase a rising edge (phase b level and a
// microsecond timestamp) or a one millisecond tick, and yields exactly one
// result beat: signed position, direction (cw, ccw, unknown), edge period
// in microseconds and rpm = floor(speed_scale / period), 0 for a zero period.
// an edge counts down when phase b is high, up otherwise, and sets the
// period from the previous edge timestamp (wrapping). ticks run a stall
// window of stall_window_ms; the first tick only arms it and sets
// ready_res. if the position did not move over a window, period clears and
// direction goes unknown. the block handles one beat at a time: a beat is
// accepted, then runs through the bit-serial restoring divider (one
// quotient bit per cycle, one for each bit of the 24-bit speed_scale)
// and is then loaded into the output register. the input side reopens
// as soon as the result sits in the output register, so the next
// divide overlaps a stalled result beat. configuration is a plain write
// port: index 0 is stall_window_ms, index 1 is speed_scale; write only
// while the block is idle.
module quadrature_encoder_speed
    import qes_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    // input beats
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic                    s_phase_b_level,
    input  logic [TS_W-1:0]         s_timestamp_us,
    // result beats
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_position,
    output logic [DIR_W-1:0]        m_direction,
    output logic [PERIOD_W-1:0]     m_period_us,
    output logic [SCALE_W-1:0]      m_speed_rpm,
    output logic                    m_ready_res
);

    qes_cmd_t    cmd;
    qes_status_t status;

    // sequencer: idle, divide, hand off to output register
    qes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // encoder state, stall window, divider and result register
    qes_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_req_type      (s_req_type),
        .s_phase_b_level (s_phase_b_level),
        .s_timestamp_us  (s_timestamp_us),
        .cmd             (cmd),
        .status          (status),
        .m_position      (m_position),
        .m_direction     (m_direction),
        .m_period_us     (m_period_us),
        .m_speed_rpm     (m_speed_rpm),
        .m_ready_res     (m_ready_res)
    );

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for quadrature_encoder_speed, top module tb
// depends on qes_pkg and the rtl of quadrature_encoder_speed only
// directed table first, then random edge and tick bursts over several register settings
module tb;
    import qes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // generous cycle budget, the slowest legal run needs well under a quarter of it
    localparam int LIMIT_CYCLES = 1_000_000;
    // wait on past the last expected result beat at the end
    localparam int TAIL_CYCLES  = 64;
    localparam int PHASE_ITEMS  = 175;
    // receiver holds off once this many result beats have gone through
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 400;

    // one result beat as the block reports it
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [DIR_W-1:0]        direction;
        logic [PERIOD_W-1:0]     period_us;
        logic [SCALE_W-1:0]      speed_rpm;
        logic                    ready_res;
    } speed_report_t;

    typedef enum bit {ROW_BEAT, ROW_CONFIG} row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t     kind;
        bit [WIN_W-1:0]   window_ms;
        bit [SCALE_W-1:0] scale;
        bit            req;
        bit            phase_b;
        bit [TS_W-1:0] stamp;
        bit            known;
        speed_report_t want;
    } script_row_t;

    // dut ports, all inputs known from time zero
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = '0;
    logic [CFG_W-1:0]        cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_req_type = REQ_EDGE;
    logic                    s_phase_b_level = 1'b0;
    logic [TS_W-1:0]         s_timestamp_us = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [POS_W-1:0] m_position;
    logic [DIR_W-1:0]        m_direction;
    logic [PERIOD_W-1:0]     m_period_us;
    logic [SCALE_W-1:0]      m_speed_rpm;
    logic                    m_ready_res;

    // predicted encoder state and register copies
    bit [COUNT_WIDTH-1:0] pred_count;
    bit [TIME_WIDTH-1:0]  pred_last_stamp;
    bit [TIME_WIDTH-1:0]  pred_period;
    bit [DIR_W-1:0]       pred_dir;
    bit [COUNT_WIDTH-1:0] pred_mark;
    bit [WIN_W-1:0]       pred_ms;
    bit                   pred_armed;
    bit [WIN_W-1:0]       cur_window_ms;
    bit [SCALE_W-1:0]     cur_scale;

    speed_report_t owed_reports[$];
    script_row_t   script[$];
    int            mismatches = 0;
    int            reports_seen = 0;
    int            cycle_count = 0;
    bit            calm = 1'b0;      // no idling on either side while set
    bit [TS_W-1:0] clock_us = '0;    // running timestamp for edge bursts

    // receiver pacing
    bit ready_level = 1'b1;
    int ready_run = 0;
    int hold_left = 0;
    bit held = 1'b0;

    quadrature_encoder_speed i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_phase_b_level (s_phase_b_level),
        .s_timestamp_us  (s_timestamp_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position      (m_position),
        .m_direction     (m_direction),
        .m_period_us     (m_period_us),
        .m_speed_rpm     (m_speed_rpm),
        .m_ready_res     (m_ready_res)
    );

    always #5 aclk = ~aclk;

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // advance the predicted decoder by one beat and report what it shows
    function automatic speed_report_t encoder_step(bit req, bit phase_b, bit [TS_W-1:0] stamp);
        speed_report_t r;
        if (req == REQ_EDGE) begin
            // period wraps when the timestamp goes backward
            pred_period     = stamp - pred_last_stamp;
            pred_last_stamp = stamp;
            if (phase_b) begin
                pred_dir   = DIR_CCW;
                pred_count = pred_count - 1'b1;
            end else begin
                pred_dir   = DIR_CW;
                pred_count = pred_count + 1'b1;
            end
        end else if (!pred_armed) begin
            // first tick only arms the stall window
            pred_mark  = pred_count;
            pred_armed = 1'b1;
            pred_ms    = '0;
        end else begin
            if (pred_ms != WIN_MAX)
                pred_ms = pred_ms + 1'b1;
            // a zero window fires on every tick, same as one ms
            if (pred_ms >= cur_window_ms) begin
                if (pred_count == pred_mark) begin
                    pred_period = '0;
                    pred_dir    = DIR_UNKNOWN;
                end
                pred_mark = pred_count;
                pred_ms   = '0;
            end
        end
        r.position  = pred_count;
        r.direction = pred_dir;
        r.period_us = pred_period;
        r.speed_rpm = (pred_period == 0) ? '0 :
                      SCALE_W'({8'd0, cur_scale} / pred_period);
        r.ready_res = pred_armed;
        return r;
    endfunction

    function automatic void add_beat(bit req, bit phase_b, bit [TS_W-1:0] stamp);
        script_row_t row;
        row = '{kind: ROW_BEAT, req: req, phase_b: phase_b, stamp: stamp, default: '0};
        script.push_back(row);
    endfunction

    // beat whose result is plain from the state, typed in directly
    function automatic void add_known(bit req, bit phase_b, bit [TS_W-1:0] stamp,
                                      speed_report_t want);
        add_beat(req, phase_b, stamp);
        script[$].known = 1'b1;
        script[$].want  = want;
    endfunction

    function automatic void add_config(bit [WIN_W-1:0] window_ms, bit [SCALE_W-1:0] scale);
        script_row_t row;
        row = '{kind: ROW_CONFIG, window_ms: window_ms, scale: scale, default: '0};
        script.push_back(row);
    endfunction

    // sender idle length, mostly none, sometimes short, rarely long
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // offer one beat, hold it until taken, then log what it should produce
    task automatic send_beat(bit req, bit phase_b, bit [TS_W-1:0] stamp, bit known,
                             speed_report_t want);
        speed_report_t predicted;
        int gap;
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_phase_b_level <= phase_b;
        s_timestamp_us  <= stamp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = encoder_step(req, phase_b, stamp);
        owed_reports.push_back(known ? want : predicted);
        gap = sender_gap();
        // valid only drops when a gap follows, never between back-to-back beats
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and let every owed result come out
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (owed_reports.size() != 0)
            @(posedge aclk);
    endtask

    // both registers back to back, block must be idle
    task automatic program_regs(bit [WIN_W-1:0] window_ms, bit [SCALE_W-1:0] scale);
        drain_reports();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_STALL_WINDOW;
        cfg_wr_data <= CFG_W'(window_ms);
        @(posedge aclk);
        cfg_addr    <= REG_SPEED_SCALE;
        cfg_wr_data <= CFG_W'(scale);
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        cur_window_ms = window_ms;
        cur_scale     = scale;
    endtask

    // random bursts: runs of edges with plausible spacing, runs of ticks, some noise
    task automatic run_random_phase(bit [WIN_W-1:0] window_ms, bit [SCALE_W-1:0] scale,
                                    bit quiet, int pause_at);
        int done;
        int pick;
        int burst;
        int k;
        bit same_way;
        bit phase_b;
        bit [TS_W-1:0] delta;
        program_regs(window_ms, scale);
        calm = quiet;
        done = 0;
        while (done < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                // edge burst, mostly one way of turning
                burst    = $urandom_range(1, 8);
                same_way = ($urandom_range(0, 4) != 0);
                phase_b  = $urandom_range(0, 1);
                for (k = 0; k < burst; k++) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        delta = '0;
                    else if (pick == 1)
                        delta = $urandom;
                    else if (pick < 5)
                        delta = $urandom_range(1, 3);
                    else
                        delta = $urandom_range(20, 20000);
                    clock_us = clock_us + delta;
                    send_beat(REQ_EDGE, same_way ? phase_b : 1'($urandom_range(0, 1)),
                              clock_us, 1'b0, '0);
                    done++;
                    if (done == pause_at)
                        drain_reports();
                end
            end else if (pick < 9) begin
                // tick burst, data fields carry junk that must be ignored
                burst = $urandom_range(1, 10);
                for (k = 0; k < burst; k++) begin
                    send_beat(REQ_TICK, 1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
                    done++;
                    if (done == pause_at)
                        drain_reports();
                end
            end else begin
                // noise beat, anything goes
                send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                          1'b0, '0);
                done++;
                if (done == pause_at)
                    drain_reports();
            end
        end
        calm = 1'b0;
    endtask

    // result side: check each beat, then pick the next ready level
    always @(posedge aclk) begin
        speed_report_t seen;
        speed_report_t owed;
        int pick;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_position, m_direction, m_period_us, m_speed_rpm, m_ready_res};
            reports_seen++;
            if (owed_reports.size() == 0) begin
                mismatches++;
                $display("%0t result beat with nothing expected: position %0d", $time,
                         seen.position);
            end else begin
                owed = owed_reports.pop_front();
                if (seen.position !== owed.position) begin
                    mismatches++;
                    $display("%0t position: expected %0d, got %0d", $time,
                             owed.position, seen.position);
                end
                if (seen.direction !== owed.direction) begin
                    mismatches++;
                    $display("%0t direction: expected %0d, got %0d", $time,
                             owed.direction, seen.direction);
                end
                if (seen.period_us !== owed.period_us) begin
                    mismatches++;
                    $display("%0t period_us: expected %0d, got %0d", $time,
                             owed.period_us, seen.period_us);
                end
                if (seen.speed_rpm !== owed.speed_rpm) begin
                    mismatches++;
                    $display("%0t speed_rpm: expected %0d, got %0d", $time,
                             owed.speed_rpm, seen.speed_rpm);
                end
                if (seen.ready_res !== owed.ready_res) begin
                    mismatches++;
                    $display("%0t ready_res: expected %0d, got %0d", $time,
                             owed.ready_res, seen.ready_res);
                end
            end
        end
        if (hold_left != 0) begin
            // long hold-off so the output register backs up into the input
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held && reports_seen >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            if (ready_run == 0) begin
                pick        = $urandom_range(0, 99);
                ready_level = (pick < 55);
                if (pick < 55)
                    ready_run = $urandom_range(1, 8);
                else if (pick < 90)
                    ready_run = $urandom_range(1, 3);
                else
                    ready_run = $urandom_range(10, 40);
            end
            ready_run--;
            m_ready <= ready_level;
        end
    end

    initial begin
        int i;

        // predictor starts from the reset state
        pred_count      = '0;
        pred_last_stamp = '0;
        pred_period     = '0;
        pred_dir        = DIR_UNKNOWN;
        pred_mark       = '0;
        pred_ms         = '0;
        pred_armed      = 1'b0;
        cur_window_ms   = STALL_WINDOW_RST;
        cur_scale       = SPEED_SCALE_RST;

        // reset register values, edges before the first tick
        add_known(REQ_EDGE, 1'b0, 32'd1000, '{32'sd1, DIR_CW, 32'd1000, 24'd600, 1'b0});
        // equal timestamps give a zero period and zero rpm
        add_known(REQ_EDGE, 1'b1, 32'd1000, '{32'sd0, DIR_CCW, 32'd0, 24'd0, 1'b0});
        // timestamp going backward wraps the period
        add_known(REQ_EDGE, 1'b1, 32'd0, '{-32'sd1, DIR_CCW, 32'hFFFF_FC18, 24'd0, 1'b0});
        // first tick arms the window and raises ready_res
        add_known(REQ_TICK, 1'b0, 32'd0, '{-32'sd1, DIR_CCW, 32'hFFFF_FC18, 24'd0, 1'b1});
        add_beat(REQ_TICK, 1'b1, 32'hFFFF_FFFF);
        add_beat(REQ_EDGE, 1'b0, 32'hFFFF_FFFF);
        add_known(REQ_EDGE, 1'b0, 32'd0, '{32'sd1, DIR_CW, 32'd1, 24'd600000, 1'b1});
        add_beat(REQ_EDGE, 1'b0, 32'd600000);
        // one ms window, second tick with no movement clears speed
        add_config(16'd1, 24'd600000);
        add_beat(REQ_TICK, 1'b0, 32'd0);
        add_known(REQ_TICK, 1'b0, 32'd0, '{32'sd2, DIR_UNKNOWN, 32'd0, 24'd0, 1'b1});
        // back and forth nets to no movement, so the window still clears
        add_beat(REQ_EDGE, 1'b1, 32'd600100);
        add_beat(REQ_EDGE, 1'b0, 32'd600200);
        add_known(REQ_TICK, 1'b1, 32'd7, '{32'sd2, DIR_UNKNOWN, 32'd0, 24'd0, 1'b1});
        // zero window acts like one ms, largest scale over the shortest period
        add_config(16'd0, 24'hFF_FFFF);
        add_known(REQ_EDGE, 1'b0, 32'd600201, '{32'sd3, DIR_CW, 32'd1, 24'hFF_FFFF, 1'b1});
        add_beat(REQ_TICK, 1'b0, 32'd0);
        add_known(REQ_TICK, 1'b0, 32'd0, '{32'sd3, DIR_UNKNOWN, 32'd0, 24'd0, 1'b1});
        // widest window, smallest scale
        add_config(16'hFFFF, 24'd1);
        add_known(REQ_EDGE, 1'b1, 32'd600202, '{32'sd2, DIR_CCW, 32'd1, 24'd1, 1'b1});
        add_beat(REQ_EDGE, 1'b1, 32'd600204);
        add_beat(REQ_TICK, 1'b0, 32'd0);
        // shrinking the window under a running timer
        add_config(16'd2, 24'd600000);
        add_beat(REQ_TICK, 1'b0, 32'd0);
        add_beat(REQ_TICK, 1'b1, 32'd0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < script.size(); i++) begin
            if (script[i].kind == ROW_CONFIG)
                program_regs(script[i].window_ms, script[i].scale);
            else
                send_beat(script[i].req, script[i].phase_b, script[i].stamp,
                          script[i].known, script[i].want);
        end

        // random part over several settings, extremes among them
        clock_us = 32'd600204;
        run_random_phase(WIN_W'($urandom_range(1, 6)), SCALE_W'($urandom_range(1, 24'hFF_FFFF)),
                         1'b0, 0);
        run_random_phase(16'd1, 24'hFF_FFFF, 1'b0, 80);
        run_random_phase(16'hFFFF, 24'd1, 1'b0, 0);
        run_random_phase(16'd0, SCALE_W'($urandom_range(1, 24'hFF_FFFF)), 1'b0, 0);
        run_random_phase(WIN_W'($urandom_range(2, 12)), 24'd600000, 1'b1, 0);
        run_random_phase(WIN_W'($urandom_range(1, 4)), SCALE_W'($urandom), 1'b0, 0);

        drain_reports();
        // catch any stray beats after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
